/* sv/lfu_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package lfu_pkg;

    // table geometry
    localparam int ENTRIES    = 16;
    localparam int KEY_BITS   = 32;
    localparam int VALUE_BITS = 32;
    localparam int CNT_BITS   = 16;
    localparam int CAP_BITS   = 5;
    localparam int IDX_BITS   = $clog2(ENTRIES);
    localparam int SCAN_BITS  = IDX_BITS + 1;
    localparam int OCC_BITS   = $clog2(ENTRIES + 1);
    localparam int CMP_BITS   = (OCC_BITS > CAP_BITS) ? OCC_BITS : CAP_BITS;

    localparam logic [CNT_BITS-1:0] COUNT_MAX = {CNT_BITS{1'b1}};
    localparam logic [CNT_BITS-1:0] COUNT_ONE = CNT_BITS'(1);
    localparam logic [CAP_BITS-1:0] CAP_RESET = CAP_BITS'(16);

    // operation codes
    localparam logic MODE_GET = 1'b0;
    localparam logic MODE_PUT = 1'b1;

    typedef struct packed {
        logic                  mode;
        logic [KEY_BITS-1:0]   lookup_key;
        logic [VALUE_BITS-1:0] write_value;
    } in_item_t;

    typedef struct packed {
        logic                  hit;
        logic [VALUE_BITS-1:0] read_value;
        logic                  evicted;
        logic [KEY_BITS-1:0]   evicted_key;
    } out_item_t;

    // one word of the entry memory
    typedef struct packed {
        logic [KEY_BITS-1:0]   key;
        logic [VALUE_BITS-1:0] value;
        logic [CNT_BITS-1:0]   count;
    } entry_t;

    // recency update broadcast to the rank cells
    typedef enum logic [1:0] {
        RANK_HOLD    = 2'd0,
        RANK_TOUCH   = 2'd1,
        RANK_INSERT  = 2'd2,
        RANK_REPLACE = 2'd3
    } rank_op_t;

    typedef struct packed {
        rank_op_t            op;
        logic [IDX_BITS-1:0] slot;
        logic [IDX_BITS-1:0] ref_rank;
    } rank_cmd_t;

endpackage

`default_nettype wire

/* sv/lfu_entry_ram.sv */
`timescale 1ns / 1ps
`default_nettype none

module lfu_entry_ram (
    input  wire logic                         clk,
    input  wire logic                         we,
    input  wire logic [lfu_pkg::IDX_BITS-1:0] waddr,
    input  wire lfu_pkg::entry_t              wdata,
    input  wire logic                         re,
    input  wire logic [lfu_pkg::IDX_BITS-1:0] raddr,
    output lfu_pkg::entry_t                   rdata
);
    import lfu_pkg::*;

    entry_t mem [ENTRIES];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

/* sv/lfu_rank_cells.sv */
`timescale 1ns / 1ps
`default_nettype none

module lfu_rank_cells (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire lfu_pkg::rank_cmd_t           cmd,
    input  wire logic [lfu_pkg::IDX_BITS-1:0] rd_idx,
    output logic [lfu_pkg::ENTRIES-1:0]       valid,
    output logic [lfu_pkg::IDX_BITS-1:0]      rd_rank
);
    import lfu_pkg::*;

    logic [ENTRIES-1:0]  valid_reg;
    logic [ENTRIES-1:0]  valid_next;
    logic [IDX_BITS-1:0] rank_reg  [ENTRIES];
    logic [IDX_BITS-1:0] rank_next [ENTRIES];

    // each cell updates its own rank from the broadcast command
    always_comb
    begin
        valid_next = valid_reg;
        for (int i = 0; i < ENTRIES; i++)
        begin
            rank_next[i] = rank_reg[i];
            unique case (cmd.op)
                RANK_HOLD:
                begin
                end
                RANK_TOUCH:
                begin
                    if (IDX_BITS'(i) == cmd.slot)
                        rank_next[i] = '0;
                    else if (valid_reg[i] && rank_reg[i] < cmd.ref_rank)
                        rank_next[i] = rank_reg[i] + IDX_BITS'(1);
                end
                RANK_INSERT:
                begin
                    if (IDX_BITS'(i) == cmd.slot)
                    begin
                        rank_next[i]  = '0;
                        valid_next[i] = 1'b1;
                    end
                    else if (valid_reg[i])
                        rank_next[i] = rank_reg[i] + IDX_BITS'(1);
                end
                RANK_REPLACE:
                begin
                    // victim leaves, newcomer takes its slot at the front
                    if (IDX_BITS'(i) == cmd.slot)
                        rank_next[i] = '0;
                    else if (valid_reg[i] && !(rank_reg[i] > cmd.ref_rank))
                        rank_next[i] = rank_reg[i] + IDX_BITS'(1);
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < ENTRIES; i++)
        begin
            rank_reg[i] <= rank_next[i];
        end
    end

    assign valid   = valid_reg;
    assign rd_rank = rank_reg[rd_idx];

endmodule

`default_nettype wire

/* sv/lfu_cache_table_core.sv */
`timescale 1ns / 1ps
`default_nettype none

// Fully associative key/value cache with least-frequently-used replacement.
// Keys, values and use counts sit in a one-port-read, one-port-write memory;
// valid bits and recency ranks live in a row of per-entry cells. Each item is
// handled one at a time: the memory is swept one entry per cycle (hit search, first
// free slot and eviction victim found in the same sweep), the last read lands,
// then an apply step writes the entry back and loads the output register. The
// input is ready again only after the write-back, so a new item is accepted
// only once the previous one has been written back. A finished result may wait
// in the output register while the next item is already being swept; the
// write-back holds only if that register is still full. The capacity register
// is written through cfg_valid/cfg_data and should only change while the block
// is idle.
module lfu_cache_table_core (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire lfu_pkg::in_item_t            in_item,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output lfu_pkg::out_item_t                out_item,
    input  wire logic                         cfg_valid,
    output logic                              cfg_ready,
    input  wire logic [lfu_pkg::CAP_BITS-1:0] cfg_data
);
    import lfu_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_SCAN  = 3'b010,
        S_APPLY = 3'b100
    } state_t;

    state_t                state_reg, state_next;
    logic [CAP_BITS-1:0]   cap_reg, cap_next;
    logic [OCC_BITS-1:0]   occ_reg, occ_next;
    in_item_t              req_reg, req_next;
    logic [SCAN_BITS-1:0]  scan_idx_reg, scan_idx_next;
    logic                  rd_vld_reg, rd_vld_next;
    logic [IDX_BITS-1:0]   rd_idx_reg, rd_idx_next;
    logic                  found_reg, found_next;
    logic [IDX_BITS-1:0]   hit_idx_reg, hit_idx_next;
    entry_t                hit_word_reg, hit_word_next;
    logic [IDX_BITS-1:0]   hit_rank_reg, hit_rank_next;
    logic                  free_found_reg, free_found_next;
    logic [IDX_BITS-1:0]   free_idx_reg, free_idx_next;
    logic                  vic_have_reg, vic_have_next;
    logic [IDX_BITS-1:0]   vic_idx_reg, vic_idx_next;
    logic [KEY_BITS-1:0]   vic_key_reg, vic_key_next;
    logic [CNT_BITS-1:0]   vic_count_reg, vic_count_next;
    logic [IDX_BITS-1:0]   vic_rank_reg, vic_rank_next;
    logic                  out_valid_reg, out_valid_next;
    out_item_t             out_item_reg, out_item_next;

    logic                  ram_we;
    logic [IDX_BITS-1:0]   ram_waddr;
    entry_t                ram_wdata;
    logic                  ram_re;
    entry_t                ram_rdata;
    rank_cmd_t             rank_cmd;
    logic [ENTRIES-1:0]    valid;
    logic [IDX_BITS-1:0]   rd_rank;

    logic                  scan_issue;
    logic                  apply_fire;
    logic [CMP_BITS-1:0]   cap_ext;
    logic [CMP_BITS-1:0]   cap_eff;
    logic                  cap_zero;
    logic                  table_full;
    logic [CNT_BITS-1:0]   count_inc;

    // entry storage: written only in the apply cycle, read only while sweeping,
    // so a read never meets a pending write to the same entry
    lfu_entry_ram u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (scan_idx_reg[IDX_BITS-1:0]),
        .rdata (ram_rdata)
    );

    // valid bits and recency ranks
    lfu_rank_cells u_cells (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (rank_cmd),
        .rd_idx  (rd_idx_reg),
        .valid   (valid),
        .rd_rank (rd_rank)
    );

    // handshakes
    assign in_ready   = (state_reg == S_IDLE);
    assign cfg_ready  = 1'b1;
    assign out_valid  = out_valid_reg;
    assign out_item   = out_item_reg;
    assign scan_issue = (state_reg == S_SCAN) && (scan_idx_reg < SCAN_BITS'(ENTRIES));
    assign ram_re     = scan_issue;
    assign apply_fire = (state_reg == S_APPLY) && (!out_valid_reg || out_ready);

    // effective capacity and fill level
    assign cap_ext    = CMP_BITS'(cap_reg);
    assign cap_eff    = (cap_ext > CMP_BITS'(ENTRIES)) ? CMP_BITS'(ENTRIES) : cap_ext;
    assign cap_zero   = (cap_eff == '0);
    assign table_full = (CMP_BITS'(occ_reg) >= cap_eff);
    assign count_inc  = (hit_word_reg.count == COUNT_MAX) ? hit_word_reg.count
                                                          : hit_word_reg.count + COUNT_ONE;

    // sequencing, sweep bookkeeping and the apply decision
    always_comb
    begin
        state_next      = state_reg;
        cap_next        = cap_reg;
        occ_next        = occ_reg;
        req_next        = req_reg;
        scan_idx_next   = scan_idx_reg;
        rd_vld_next     = scan_issue;
        rd_idx_next     = scan_idx_reg[IDX_BITS-1:0];
        found_next      = found_reg;
        hit_idx_next    = hit_idx_reg;
        hit_word_next   = hit_word_reg;
        hit_rank_next   = hit_rank_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        vic_have_next   = vic_have_reg;
        vic_idx_next    = vic_idx_reg;
        vic_key_next    = vic_key_reg;
        vic_count_next  = vic_count_reg;
        vic_rank_next   = vic_rank_reg;
        out_valid_next  = out_valid_reg;
        out_item_next   = out_item_reg;
        ram_we          = 1'b0;
        ram_waddr       = hit_idx_reg;
        ram_wdata       = hit_word_reg;
        rank_cmd        = '{op: RANK_HOLD, slot: hit_idx_reg, ref_rank: hit_rank_reg};

        // configuration write
        if (cfg_valid)
            cap_next = cfg_data;

        // output register drains
        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        // one memory word arrives per cycle during the sweep
        if (rd_vld_reg)
        begin
            if (valid[rd_idx_reg] && ram_rdata.key == req_reg.lookup_key && !found_reg)
            begin
                found_next    = 1'b1;
                hit_idx_next  = rd_idx_reg;
                hit_word_next = ram_rdata;
                hit_rank_next = rd_rank;
            end
            if (!valid[rd_idx_reg] && !free_found_reg)
            begin
                free_found_next = 1'b1;
                free_idx_next   = rd_idx_reg;
            end
            if (valid[rd_idx_reg] && (!vic_have_reg || ram_rdata.count < vic_count_reg ||
                (ram_rdata.count == vic_count_reg && rd_rank > vic_rank_reg)))
            begin
                vic_have_next  = 1'b1;
                vic_idx_next   = rd_idx_reg;
                vic_key_next   = ram_rdata.key;
                vic_count_next = ram_rdata.count;
                vic_rank_next  = rd_rank;
            end
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    req_next        = in_item;
                    scan_idx_next   = '0;
                    found_next      = 1'b0;
                    free_found_next = 1'b0;
                    vic_have_next   = 1'b0;
                    state_next      = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (scan_issue)
                    scan_idx_next = scan_idx_reg + SCAN_BITS'(1);
                else
                    state_next = S_APPLY;
            end
            S_APPLY:
            begin
                if (apply_fire)
                begin
                    out_valid_next            = 1'b1;
                    out_item_next.hit         = found_reg;
                    out_item_next.read_value  = '0;
                    out_item_next.evicted     = 1'b0;
                    out_item_next.evicted_key = '0;
                    state_next                = S_IDLE;

                    if (found_reg && (req_reg.mode == MODE_GET || !cap_zero))
                    begin
                        // hit: bump count, refresh recency, put replaces value
                        if (req_reg.mode == MODE_GET)
                            out_item_next.read_value = hit_word_reg.value;
                        ram_we          = 1'b1;
                        ram_waddr       = hit_idx_reg;
                        ram_wdata       = hit_word_reg;
                        ram_wdata.count = count_inc;
                        if (req_reg.mode == MODE_PUT)
                            ram_wdata.value = req_reg.write_value;
                        rank_cmd = '{op: RANK_TOUCH, slot: hit_idx_reg,
                                     ref_rank: hit_rank_reg};
                    end
                    else if (!found_reg && req_reg.mode == MODE_PUT && !cap_zero)
                    begin
                        // put miss: insert, evicting the victim when full
                        ram_we    = 1'b1;
                        ram_wdata = '{key: req_reg.lookup_key,
                                      value: req_reg.write_value,
                                      count: COUNT_ONE};
                        if (table_full)
                        begin
                            ram_waddr                 = vic_idx_reg;
                            out_item_next.evicted     = 1'b1;
                            out_item_next.evicted_key = vic_key_reg;
                            rank_cmd = '{op: RANK_REPLACE, slot: vic_idx_reg,
                                         ref_rank: vic_rank_reg};
                        end
                        else
                        begin
                            ram_waddr = free_idx_reg;
                            occ_next  = occ_reg + OCC_BITS'(1);
                            rank_cmd  = '{op: RANK_INSERT, slot: free_idx_reg,
                                          ref_rank: vic_rank_reg};
                        end
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            cap_reg        <= CAP_RESET;
            occ_reg        <= '0;
            scan_idx_reg   <= '0;
            rd_vld_reg     <= 1'b0;
            found_reg      <= 1'b0;
            free_found_reg <= 1'b0;
            vic_have_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cap_reg        <= cap_next;
            occ_reg        <= occ_next;
            scan_idx_reg   <= scan_idx_next;
            rd_vld_reg     <= rd_vld_next;
            found_reg      <= found_next;
            free_found_reg <= free_found_next;
            vic_have_reg   <= vic_have_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        req_reg       <= req_next;
        rd_idx_reg    <= rd_idx_next;
        hit_idx_reg   <= hit_idx_next;
        hit_word_reg  <= hit_word_next;
        hit_rank_reg  <= hit_rank_next;
        free_idx_reg  <= free_idx_next;
        vic_idx_reg   <= vic_idx_next;
        vic_key_reg   <= vic_key_next;
        vic_count_reg <= vic_count_next;
        vic_rank_reg  <= vic_rank_next;
        out_item_reg  <= out_item_next;
    end

endmodule

`default_nettype wire

/* test/tb_lfu_cache_table_core.sv */
`timescale 1ns / 1ps

module tb_lfu_cache_table_core;

    import lfu_pkg::*;

    localparam int CYCLE_LIMIT = 6000000;
    localparam int HOLD_CYCLES = 400;
    localparam int PHASE_OPS   = 190;
    localparam int PRINT_LIMIT = 40;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_ready;
    in_item_t          in_item = '0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    out_item_t         out_item;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [CAP_BITS-1:0] cfg_data = '0;

    // shadow copy of the cache contents
    logic                  tbl_valid [ENTRIES];
    logic [KEY_BITS-1:0]   tbl_key   [ENTRIES];
    logic [VALUE_BITS-1:0] tbl_value [ENTRIES];
    logic [CNT_BITS-1:0]   tbl_count [ENTRIES];
    int                    tbl_rank  [ENTRIES];
    int                    tbl_fill;
    logic [CAP_BITS-1:0]   cap_setting;

    in_item_t  ops_to_send [$];
    out_item_t replies_due [$];
    out_item_t due_reply;

    int   send_idle_pct = 0;
    int   recv_idle_pct = 0;
    int   hold_left = 0;
    logic hold_request = 1'b0;
    int   cycle_count = 0;
    int   mismatch_count = 0;

    lfu_cache_table_core DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // clock
    initial
    begin
        forever #5 clk = ~clk;
    end

    // reset
    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d replies outstanding",
                     cycle_count, replies_due.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    // move an entry to the front of the recency order and bump its count
    function automatic void promote_entry(int h);
        int r;
        r = tbl_rank[h];
        for (int i = 0; i < ENTRIES; i++)
            if (tbl_valid[i] && tbl_rank[i] < r)
                tbl_rank[i]++;
        tbl_rank[h] = 0;
        if (tbl_count[h] != COUNT_MAX)
            tbl_count[h]++;
    endfunction

    // apply one get or put to the shadow cache, return the reply it gives
    function automatic out_item_t apply_cache_access(in_item_t op);
        out_item_t reply;
        int        hit_idx;
        int        slot;
        int        cap;
        int        victim_rank;
        reply   = '0;
        hit_idx = -1;
        for (int i = 0; i < ENTRIES; i++)
            if (hit_idx < 0 && tbl_valid[i] && tbl_key[i] == op.lookup_key)
                hit_idx = i;

        if (op.mode == MODE_GET)
        begin
            if (hit_idx >= 0)
            begin
                reply.hit        = 1'b1;
                reply.read_value = tbl_value[hit_idx];
                promote_entry(hit_idx);
            end
            return reply;
        end

        cap = (int'(cap_setting) > ENTRIES) ? ENTRIES : int'(cap_setting);
        if (hit_idx >= 0)
        begin
            reply.hit = 1'b1;
            if (cap != 0)
            begin
                tbl_value[hit_idx] = op.write_value;
                promote_entry(hit_idx);
            end
            return reply;
        end
        if (cap == 0)
            return reply;

        slot = -1;
        if (tbl_fill >= cap)
        begin
            // lowest count wins, oldest touch breaks ties
            for (int i = 0; i < ENTRIES; i++)
                if (tbl_valid[i] && (slot < 0 || tbl_count[i] < tbl_count[slot] ||
                    (tbl_count[i] == tbl_count[slot] && tbl_rank[i] > tbl_rank[slot])))
                    slot = i;
            victim_rank = tbl_rank[slot];
            for (int i = 0; i < ENTRIES; i++)
                if (tbl_valid[i] && tbl_rank[i] > victim_rank)
                    tbl_rank[i]--;
            tbl_valid[slot]   = 1'b0;
            tbl_fill          = tbl_fill - 1;
            reply.evicted     = 1'b1;
            reply.evicted_key = tbl_key[slot];
        end
        else
        begin
            for (int i = 0; i < ENTRIES; i++)
                if (slot < 0 && !tbl_valid[i])
                    slot = i;
        end

        // insert as most recent with count one
        for (int i = 0; i < ENTRIES; i++)
            if (tbl_valid[i])
                tbl_rank[i]++;
        tbl_valid[slot] = 1'b1;
        tbl_key[slot]   = op.lookup_key;
        tbl_value[slot] = op.write_value;
        tbl_count[slot] = COUNT_ONE;
        tbl_rank[slot]  = 0;
        tbl_fill        = tbl_fill + 1;
        return reply;
    endfunction

    task automatic flag_mismatch(string what, logic [31:0] got, logic [31:0] want);
        if (mismatch_count < PRINT_LIMIT)
            $display("mismatch at cycle %0d: %s got %h expected %h",
                     cycle_count, what, got, want);
        mismatch_count++;
    endtask

    // item driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_item  <= '0;
        end
        else
        begin
            if (in_valid && in_ready)
                replies_due.push_back(apply_cache_access(in_item));
            if (!in_valid || in_ready)
            begin
                if (ops_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    in_item  <= ops_to_send.pop_front();
                    in_valid <= 1'b1;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // long receiver hold-off
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hold_left <= 0;
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
        else if (hold_request)
            hold_left <= HOLD_CYCLES;
    end

    // reply monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                if (replies_due.size() == 0)
                    flag_mismatch("unexpected item, read_value", out_item.read_value, '0);
                else
                begin
                    due_reply = replies_due.pop_front();
                    if (out_item.hit !== due_reply.hit)
                        flag_mismatch("hit", out_item.hit, due_reply.hit);
                    if (out_item.read_value !== due_reply.read_value)
                        flag_mismatch("read_value", out_item.read_value,
                                      due_reply.read_value);
                    if (out_item.evicted !== due_reply.evicted)
                        flag_mismatch("evicted", out_item.evicted, due_reply.evicted);
                    if (out_item.evicted_key !== due_reply.evicted_key)
                        flag_mismatch("evicted_key", out_item.evicted_key,
                                      due_reply.evicted_key);
                end
            end
            out_ready <= (hold_left == 0) && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic queue_op(logic m, logic [KEY_BITS-1:0] k, logic [VALUE_BITS-1:0] v);
        in_item_t op;
        op.mode        = m;
        op.lookup_key  = k;
        op.write_value = v;
        ops_to_send.push_back(op);
    endtask

    // wait until every item is sent and every reply is back
    task automatic wait_drained();
        do
            @(negedge clk);
        while (ops_to_send.size() != 0 || in_valid || replies_due.size() != 0);
        repeat (20) @(negedge clk);
    endtask

    task automatic set_capacity(logic [CAP_BITS-1:0] cap);
        @(posedge clk);
        cfg_data  <= cap;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid   <= 1'b0;
        cap_setting = cap;
    endtask

    // stimulus sequence
    initial
    begin
        int                  caps [9];
        logic [KEY_BITS-1:0] key_pool [$];
        logic [KEY_BITS-1:0] k;
        int                  pool_size;
        int                  a;
        int                  b;

        for (int i = 0; i < ENTRIES; i++)
        begin
            tbl_valid[i] = 1'b0;
            tbl_key[i]   = '0;
            tbl_value[i] = '0;
            tbl_count[i] = '0;
            tbl_rank[i]  = 0;
        end
        tbl_fill    = 0;
        cap_setting = CAP_RESET;
        caps        = '{31, 6, 16, 2, 0, 11, 1, 20, 16};
        caps[8]     = $urandom_range(0, 31);
        send_idle_pct = 37;
        recv_idle_pct = 63;
        wait (rst_n);

        // basic get and put at the reset capacity, extreme keys and values
        queue_op(MODE_GET, '0, '1);
        queue_op(MODE_PUT, '0, '1);
        queue_op(MODE_PUT, '1, '0);
        queue_op(MODE_GET, '0, '0);
        queue_op(MODE_GET, '1, '1);
        queue_op(MODE_PUT, '0, 32'h1234_5678);
        queue_op(MODE_GET, '0, '0);
        wait_drained();

        // zero capacity: puts change nothing, gets still work
        set_capacity(0);
        queue_op(MODE_PUT, 32'd5, 32'hAAAA_5555);
        queue_op(MODE_PUT, '0, '1);
        queue_op(MODE_GET, '0, '0);
        queue_op(MODE_GET, 32'd5, '0);
        wait_drained();

        // capacity below occupancy: each put miss evicts one first
        set_capacity(1);
        queue_op(MODE_PUT, 32'd77, 32'd1);
        queue_op(MODE_PUT, 32'd88, 32'd2);
        queue_op(MODE_GET, 32'd77, '0);
        queue_op(MODE_GET, 32'd88, '0);
        wait_drained();

        // equal counts: the least recently touched goes first
        set_capacity(4);
        queue_op(MODE_PUT, 32'd300, 32'h0000_0300);
        queue_op(MODE_PUT, 32'd301, 32'h0000_0301);
        queue_op(MODE_PUT, 32'd302, 32'h0000_0302);
        queue_op(MODE_PUT, 32'd303, 32'h0000_0303);
        queue_op(MODE_GET, 32'd302, '0);
        queue_op(MODE_PUT, 32'd304, 32'h0000_0304);
        wait_drained();

        // one more put miss on the full table, the lone single-count entry leaves
        queue_op(MODE_PUT, 32'd305, 32'h0000_0305);
        queue_op(MODE_GET, '0, '0);
        queue_op(MODE_GET, 32'd304, '0);
        wait_drained();

        // random phases over several capacities
        for (int ph = 0; ph < 9; ph++)
        begin
            set_capacity(CAP_BITS'(caps[ph]));
            if (ph < 3)
            begin
                send_idle_pct = 37;
                recv_idle_pct = 63;
            end
            else if (ph < 6)
            begin
                send_idle_pct = 63;
                recv_idle_pct = 37;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end

            // key pool of 2 to 28 keys, with a few extreme keys
            key_pool.delete();
            pool_size = $urandom_range(2, 28);
            for (int i = 0; i < pool_size; i++)
            begin
                case ($urandom_range(0, 9))
                    0:       k = '0;
                    1:       k = '1;
                    default: k = $urandom;
                endcase
                key_pool.push_back(k);
            end

            // skewed picks so some keys build up much higher counts
            for (int n = 0; n < PHASE_OPS; n++)
            begin
                if ($urandom_range(0, 99) < 12)
                    k = $urandom;
                else
                begin
                    a = $urandom_range(0, pool_size - 1);
                    b = $urandom_range(0, pool_size - 1);
                    k = key_pool[(a < b) ? a : b];
                end
                queue_op(1'($urandom_range(0, 1)), k, $urandom);
            end

            // stall the receiver while the sender keeps offering
            if (ph == 1 || ph == 7)
            begin
                @(negedge clk);
                hold_request = 1'b1;
                wait (hold_left != 0);
                hold_request = 1'b0;
            end
            wait_drained();
        end

        repeat (40) @(negedge clk);
        if (mismatch_count == 0 && replies_due.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
